FILE: rtl/core/hri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hri_pkg: shared constants for the Halton radical inverse core
// Field widths, fixed-point sizes and the reciprocal-multiply geometry.
// ----------------------------------------------------------------------------
package hri_pkg;

  // sizes
  localparam int INDEX_BITS    = 32;
  localparam int FRACTION_BITS = 32;

  // word fields
  localparam int IDX_W  = 32;
  localparam int RAD_W  = 8;
  localparam int FRAC_W = 32;

  // weight starts at 2^FRACTION_BITS, so it needs one more bit
  localparam int WGT_W = FRACTION_BITS + 1;

  // x / b == (x * ceil(2^S / b)) >> S, exact for x < 2^WGT_W, b < 2^RAD_W
  localparam int RCP_SHIFT = WGT_W + RAD_W;
  localparam int RCP_W     = RCP_SHIFT;
  localparam int RCP_DEPTH = 2 ** RAD_W;

  // shared multiplier: WGT_W x MLO_W, reciprocal applied in two halves
  localparam int MLO_W  = (RCP_W + 1) / 2;
  localparam int MHI_W  = RCP_W - MLO_W;
  localparam int MA_W   = WGT_W;
  localparam int MB_W   = MLO_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W + MLO_W;

  localparam logic [RAD_W-1:0] MIN_RADIX = RAD_W'(2);

  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  localparam logic [WGT_W-1:0] WGT_INIT = WGT_W'(1) << FRACTION_BITS;

endpackage

FILE: rtl/core/halton_radical_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halton_radical_inverse_top: radical inverse of a sample index in base radix
// Iterative core around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word = {radix, sample_index}; accepted on tvalid & tready.
//   out_* : one word per input: tdata = fraction (value / 2^32),
//           tuser = bad_radix (radix below 2, fraction then 0).
//   The core works on one word at a time; in_tready is high only while the
//   sequencer is idle, so a new word is taken only after the last result has gone to the output register.
// Sequence from accept to out_tvalid:
//   radix below 2 or index zero : straight to the final state
//   otherwise                   : six multiplier passes for each base-radix
//                                 digit of the index, then the final state.
//   The six passes per digit all go through the one multiplier:
//   two halves of index / radix, two halves of weight / radix, quotient
//   times radix for the digit, digit times weight for the sum.
// Reset (rst_n low, synchronous) empties the core and drops out_tvalid.
// If the receiver stalls, the finished result holds in the output register
// and the core waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module halton_radical_inverse_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] sample_index, [39:32] radix
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] fraction
  output logic        out_tuser   // [0] bad_radix
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL_IL = 8'b0000_0010,  // index * recip low
    ST_MUL_IH = 8'b0000_0100,  // index * recip high
    ST_MUL_WL = 8'b0000_1000,  // weight * recip low
    ST_MUL_WH = 8'b0001_0000,  // weight * recip high
    ST_MUL_QB = 8'b0010_0000,  // quotient * radix
    ST_MUL_DW = 8'b0100_0000,  // weight * digit
    ST_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [hri_pkg::FRAC_W-1:0]  out_frac_r;
  logic                        out_bad_r;

  logic [hri_pkg::IDX_W-1:0]   idx_r;
  logic [hri_pkg::RAD_W-1:0]   radix_r;
  logic [hri_pkg::RCP_W-1:0]   m_r;
  logic [hri_pkg::WGT_W-1:0]   w_r;
  logic [hri_pkg::WGT_W-1:0]   q_r;
  logic [hri_pkg::PROD_W-1:0]  prod_r;
  logic [hri_pkg::PROD_W-1:0]  sum_r;
  logic [hri_pkg::FRAC_W-1:0]  frac_r;
  logic                        bad_r;

  logic [hri_pkg::RCP_W-1:0]   rcp_tab [hri_pkg::RCP_DEPTH];
  logic [hri_pkg::MA_W-1:0]    mul_a;
  logic [hri_pkg::MB_W-1:0]    mul_b;
  logic [hri_pkg::PROD_W-1:0]  mul_prod;
  logic [hri_pkg::SUM_W-1:0]   wsum;
  logic [hri_pkg::WGT_W-1:0]   wquot;
  logic [hri_pkg::RAD_W-1:0]   digit;
  logic [hri_pkg::FRAC_W:0]    frac_fin;

  logic [hri_pkg::IDX_W-1:0]   in_index;
  logic [hri_pkg::RAD_W-1:0]   in_radix;
  logic                        in_fire;
  logic                        out_free;

  assign in_index = in_tdata[hri_pkg::IDX_W-1:0] & hri_pkg::IDX_MASK;
  assign in_radix = in_tdata[hri_pkg::IDX_W +: hri_pkg::RAD_W];
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_frac_r;
  assign out_tuser  = out_bad_r;

  // reciprocal table ceil(2^S / b); entries below 2 are never used
  for (genvar g = 0; g < hri_pkg::RCP_DEPTH; g++) begin : g_rcp
    localparam longint unsigned D = (g < 2) ? 2 : g;
    localparam longint unsigned M = ((64'd1 << hri_pkg::RCP_SHIFT) + D - 64'd1) / D;
    assign rcp_tab[g] = hri_pkg::RCP_W'(M);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_IL: begin
        mul_a = hri_pkg::MA_W'(idx_r);
        mul_b = m_r[hri_pkg::MLO_W-1:0];
      end
      ST_MUL_IH: begin
        mul_a = hri_pkg::MA_W'(idx_r);
        mul_b = hri_pkg::MB_W'(m_r[hri_pkg::RCP_W-1:hri_pkg::MLO_W]);
      end
      ST_MUL_WL: begin
        mul_a = w_r;
        mul_b = m_r[hri_pkg::MLO_W-1:0];
      end
      ST_MUL_WH: begin
        mul_a = w_r;
        mul_b = hri_pkg::MB_W'(m_r[hri_pkg::RCP_W-1:hri_pkg::MLO_W]);
      end
      ST_MUL_QB: begin
        mul_a = q_r;
        mul_b = hri_pkg::MB_W'(radix_r);
      end
      ST_MUL_DW: begin
        mul_a = w_r;
        mul_b = hri_pkg::MB_W'(digit);
      end
      ST_IDLE, ST_FIN: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = {{hri_pkg::MB_W{1'b0}}, mul_a} * {{hri_pkg::MA_W{1'b0}}, mul_b};

  // low half plus shifted high half, then drop the reciprocal scale
  assign wsum  = {{hri_pkg::MLO_W{1'b0}}, sum_r} + {prod_r, {hri_pkg::MLO_W{1'b0}}};
  assign wquot = wsum[hri_pkg::RCP_SHIFT +: hri_pkg::WGT_W];

  // remainder < radix fits a byte, so only the low bytes matter
  assign digit = idx_r[hri_pkg::RAD_W-1:0] - prod_r[hri_pkg::RAD_W-1:0];

  assign frac_fin = {1'b0, frac_r} + {1'b0, prod_r[hri_pkg::FRAC_W-1:0]};

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_radix < hri_pkg::MIN_RADIX || in_index == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL_IL;
          end
        end
      end
      ST_MUL_IL: state_nxt = ST_MUL_IH;
      ST_MUL_IH: state_nxt = ST_MUL_WL;
      ST_MUL_WL: state_nxt = ST_MUL_WH;
      ST_MUL_WH: state_nxt = ST_MUL_QB;
      ST_MUL_QB: state_nxt = ST_MUL_DW;
      ST_MUL_DW: begin
        if (q_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_MUL_IL;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_r   <= in_index;
          radix_r <= in_radix;
          m_r     <= rcp_tab[in_radix];
          w_r     <= hri_pkg::WGT_INIT;
          prod_r  <= '0;
          frac_r  <= '0;
          bad_r   <= (in_radix < hri_pkg::MIN_RADIX);
        end
      end
      ST_MUL_IL: begin
        prod_r <= mul_prod;
        frac_r <= frac_fin[hri_pkg::FRAC_W-1:0];
      end
      ST_MUL_IH: begin
        prod_r <= mul_prod;
        sum_r  <= prod_r;
      end
      ST_MUL_WL: begin
        prod_r <= mul_prod;
        q_r    <= wquot;
      end
      ST_MUL_WH: begin
        prod_r <= mul_prod;
        sum_r  <= prod_r;
      end
      ST_MUL_QB: begin
        prod_r <= mul_prod;
        w_r    <= wquot;
      end
      ST_MUL_DW: begin
        prod_r <= mul_prod;
        idx_r  <= q_r[hri_pkg::IDX_W-1:0];
      end
      ST_FIN: begin
        if (out_free) begin
          out_frac_r <= frac_fin[hri_pkg::FRAC_W-1:0];
          out_bad_r  <= bad_r;
        end
      end
      default: begin
        prod_r <= prod_r;
      end
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad_radix word with nonzero fraction");

  a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[39:33] == '0 |=> state_r == ST_FIN)
    else $error("radix below 2 did not go straight to final state");

  a_digit_rng: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_DW |-> digit < radix_r)
    else $error("digit not below radix, reciprocal divide off");

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> frac_fin[hri_pkg::FRAC_W] == 1'b0)
    else $error("fraction sum overflowed");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream-level test of the Halton radical inverse core
// Drives sample index / radix words, predicts each fraction and radix flag
// in fixed point, and checks every result word in order. Covers corner
// radices and indices, truncated weights that reach zero, output stalls long
// enough to back up the input, and random traffic with and without idling.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [hri_pkg::FRAC_W-1:0] fraction;
    logic                       bad_radix;
  } inverse_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] sample_index, [39:32] radix
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] fraction
  logic        out_tuser;  // [0] bad_radix

  inverse_t inverse_q[$];
  int       n_fail;
  bit       idle_en;
  int       sink_hold_cycles;

  halton_radical_inverse_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // digits of the index, least significant first, mirrored behind the point
  function automatic inverse_t radical_inverse(logic [hri_pkg::IDX_W-1:0] index,
                                               logic [hri_pkg::RAD_W-1:0] radix);
    logic [63:0] n;
    logic [63:0] b;
    logic [63:0] wgt;
    logic [63:0] acc;
    inverse_t    r;
    n   = {32'd0, index & hri_pkg::IDX_MASK};
    b   = {56'd0, radix};
    wgt = 64'd1 << hri_pkg::FRACTION_BITS;
    acc = 64'd0;
    if (radix < hri_pkg::MIN_RADIX) begin
      r.fraction  = '0;
      r.bad_radix = 1'b1;
      return r;
    end
    while (n != 64'd0) begin
      wgt = wgt / b;
      acc = acc + (n % b) * wgt;
      n   = n / b;
    end
    r.fraction  = acc[hri_pkg::FRAC_W-1:0];
    r.bad_radix = 1'b0;
    return r;
  endfunction

  // valid stays high across back-to-back words; one NBA per edge
  task automatic send_word(input logic [hri_pkg::IDX_W-1:0] index,
                           input logic [hri_pkg::RAD_W-1:0] radix);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {radix, index};
    do @(posedge clk); while (!in_tready);
    inverse_q.push_back(radical_inverse(index, radix));
  endtask

  task automatic wait_drained();
    while (inverse_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_corners();
    send_word(32'd0, 8'd2);
    send_word(32'd1, 8'd2);
    send_word(32'hFFFF_FFFF, 8'd2);
    send_word(32'h8000_0000, 8'd2);
    send_word(32'hFFFF_FFFF, 8'd3);
    send_word(32'd1, 8'd255);
    send_word(32'd254, 8'd255);
    send_word(32'd255, 8'd255);
    // five digits: the weight truncates to zero before the last one
    send_word(32'hFFFF_FFFF, 8'd255);
    send_word(32'hFFFF_FFFF, 8'd200);
    send_word(32'hFFFF_FFFF, 8'd254);
    send_word(32'hAAAA_5555, 8'd128);
    send_word(32'h0000_0000, 8'd255);
  endtask

  task automatic test_bad_radix();
    send_word(32'd0, 8'd0);
    send_word(32'd0, 8'd1);
    send_word(32'hFFFF_FFFF, 8'd0);
    send_word(32'hFFFF_FFFF, 8'd1);
    send_word(32'h1234_5678, 8'd1);
  endtask

  // output held off long enough that the core fills and input stalls
  task automatic test_backpressure();
    idle_en = 1'b0;
    sink_hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      send_word($urandom(), 8'($urandom_range(2, 9)));
    end
    idle_en = 1'b1;
  endtask

  // sender stops until every result word is back
  task automatic test_drain_pause();
    send_word($urandom(), 8'd2);
    send_word($urandom(), 8'd7);
    in_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    send_word($urandom(), 8'd5);
    send_word(32'd0, 8'd1);
  endtask

  task automatic random_word();
    logic [hri_pkg::IDX_W-1:0] index;
    logic [hri_pkg::RAD_W-1:0] radix;
    int                        pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)      radix = 8'($urandom_range(0, 1));
    else if (pick < 7)  radix = 8'($urandom_range(2, 16));
    else                radix = 8'($urandom_range(2, 255));
    if ($urandom_range(0, 4) == 0) index = 32'($urandom_range(0, 255));
    else                           index = $urandom();
    send_word(index, radix);
  endtask

  task automatic test_random_idle(input int count);
    idle_en = 1'b1;
    repeat (count) random_word();
  endtask

  task automatic test_random_streaming(input int count);
    idle_en = 1'b0;
    repeat (count) random_word();
  endtask

  initial begin : sink
    int len;
    forever begin
      if (sink_hold_cycles > 0) begin
        len = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check
    inverse_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected word: fraction %h bad_radix %b", out_tdata, out_tuser);
        n_fail++;
      end else begin
        want = inverse_q.pop_front();
        if (out_tdata !== want.fraction) begin
          $error("fraction: expected %h, actual %h", want.fraction, out_tdata);
          n_fail++;
        end
        if (out_tuser !== want.bad_radix) begin
          $error("bad_radix: expected %b, actual %b", want.bad_radix, out_tuser);
          n_fail++;
        end
      end
    end
  end

  initial begin
    n_fail = 0;
    idle_en = 1'b1;
    sink_hold_cycles = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_bad_radix();
    test_backpressure();
    test_drain_pause();
    test_random_idle(320);
    test_random_streaming(80);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
